FILE: rtl/core/hotp_pkg.sv
package hotp_pkg;

   localparam int KEY_BYTES    = 20;
   localparam int WINDOW_BACK  = 4;
   localparam int WINDOW_AHEAD = 4;
   localparam int WINDOW_CODES = WINDOW_BACK + WINDOW_AHEAD;
   localparam int WIN_W        = $clog2(WINDOW_CODES + 1);

   localparam int CODE_W   = 20;
   localparam int STEP_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MIDDLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 2'd2;

   localparam logic OP_GENERATE = 1'b0;
   localparam logic OP_CHECK    = 1'b1;

   localparam int unsigned CODE_MODULUS = 1000000;
   localparam int MOD_STEPS = 12;
   localparam logic [30:0] WORD_MASK = 31'h7fff_ffff;
   localparam int ROUNDS = 80;

   // Which of the four compressions of one code is in progress.
   localparam logic [1:0] PH_KEY_INNER = 2'd0;
   localparam logic [1:0] PH_KEY_OUTER = 2'd1;
   localparam logic [1:0] PH_MSG_INNER = 2'd2;
   localparam logic [1:0] PH_MSG_OUTER = 2'd3;

   typedef logic [31:0] word_type;
   typedef word_type sched_type [16];
   typedef word_type chain_type [5];

   localparam logic [159:0] SHA_INIT = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                        32'h10325476, 32'hC3D2E1F0};

   function automatic word_type rotl(input word_type x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [511:0] build_block(input logic [1:0] phase,
                                                input logic [63:0] key_high,
                                                input logic [63:0] key_middle,
                                                input logic [31:0] key_low,
                                                input word_type counter,
                                                input logic [159:0] digest);
      logic [511:0] key_blk;
      key_blk = {key_high, key_middle, key_low, 352'd0};
      unique case (phase)
         PH_KEY_INNER: build_block = key_blk ^ {64{8'h36}};
         PH_KEY_OUTER: build_block = key_blk ^ {64{8'h5c}};
         // Second block of the inner hash: zero word, counter, padding, 576-bit length.
         PH_MSG_INNER: build_block = {32'd0, counter, 32'h8000_0000, 384'd0, 32'd576};
         default:      build_block = {digest, 32'h8000_0000, 288'd0, 32'd672};
      endcase
   endfunction

   function automatic logic [30:0] truncate(input logic [159:0] digest);
      logic [159:0] shifted;
      shifted = digest << {digest[3:0], 3'b000};
      truncate = shifted[158:128] & WORD_MASK;
   endfunction

endpackage

FILE: rtl/core/hotp_if.sv
interface hotp_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] time_step;
   logic [19:0] token;
   modport source(output valid, operation, time_step, token, input ready);
   modport sink(input valid, operation, time_step, token, output ready);
endinterface

interface hotp_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] code;
   logic        match;
   modport source(output valid, code, match, input ready);
   modport sink(input valid, code, match, output ready);
endinterface

interface hotp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/hotp_sha1_token_check_unit.sv
// Each SHA-1 compression runs one round a cycle on a single round unit.
// Keyed pad states are compressed once per item and kept in a two-entry state memory.
// The modulo 1000000 reduction is done by repeated compare-subtract for each code.
// One item at a time; the next beat is taken while a result waits to be collected.
// Synchronous active-high reset clears the key registers, the state register and the response valid flag.
module hotp_sha1_token_check_unit (
   input logic clock,
   input logic reset,
   hotp_req_if.sink   req_if,
   hotp_rsp_if.source rsp_if,
   hotp_csr_if.sink   csr_if
);
   import hotp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_RND   = 3'd3;
   localparam logic [2:0] S_WB    = 3'd4;
   localparam logic [2:0] S_TRUNC = 3'd5;
   localparam logic [2:0] S_MOD   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [63:0] key_high_ff, key_middle_ff;
   logic [31:0] key_low_ff;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [6:0]  round_ff, round_in;
   sched_type   w_ff, w_in;
   chain_type   s_ff, s_in;
   logic [159:0] h_ff, h_in;
   logic [159:0] dig_ff, dig_in;
   logic [30:0] rem_ff, rem_in;
   logic [3:0]  modk_ff, modk_in;
   logic [WIN_W-1:0] idx_ff, idx_in;
   word_type    ctr_ff, ctr_in;
   logic        op_ff, op_in;
   logic [19:0] token_ff, token_in;
   logic        hit_ff, hit_in;
   logic [19:0] gcode_ff, gcode_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_code_ff, rsp_code_in;
   logic        rsp_match_ff, rsp_match_in;

   // Keyed pad states: entry 0 inner, entry 1 outer.
   logic [159:0] kmem [2];
   logic [159:0] rdata_ff;

   logic [159:0] sum;
   logic [511:0] blk;
   word_type     f, k, t, wnew;
   logic [31:0]  sub;
   logic [30:0]  rem_next;
   logic [WIN_W-1:0] codes;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.code  = rsp_code_ff;
   assign rsp_if.match = rsp_match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_middle_ff <= '0;
         key_low_ff    <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_KEY_HIGH:   key_high_ff   <= csr_if.data;
            CSR_KEY_MIDDLE: key_middle_ff <= csr_if.data;
            CSR_KEY_LOW:    key_low_ff    <= csr_if.data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WB && !phase_ff[1]) begin
         kmem[phase_ff[0]] <= sum;
      end
      rdata_ff <= kmem[phase_ff[0]];
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         sum[159-32*i -: 32] = h_ff[159-32*i -: 32] + s_ff[i];
      end
      blk = build_block(phase_ff, key_high_ff, key_middle_ff, key_low_ff, ctr_ff, dig_ff);
      if (round_ff < 7'd20) begin
         f = (s_ff[1] & s_ff[2]) | (~s_ff[1] & s_ff[3]);
         k = 32'h5A827999;
      end else if (round_ff < 7'd40) begin
         f = s_ff[1] ^ s_ff[2] ^ s_ff[3];
         k = 32'h6ED9EBA1;
      end else if (round_ff < 7'd60) begin
         f = (s_ff[1] & s_ff[2]) | (s_ff[1] & s_ff[3]) | (s_ff[2] & s_ff[3]);
         k = 32'h8F1BBCDC;
      end else begin
         f = s_ff[1] ^ s_ff[2] ^ s_ff[3];
         k = 32'hCA62C1D6;
      end
      t    = rotl(s_ff[0], 5) + f + s_ff[4] + k + w_ff[0];
      wnew = rotl(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
      sub  = 32'(CODE_MODULUS) << modk_ff;
      rem_next = ({1'b0, rem_ff} >= sub) ? 31'({1'b0, rem_ff} - sub) : rem_ff;
      codes = (op_ff == OP_CHECK) ? WIN_W'(WINDOW_CODES) : WIN_W'(1);
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      round_in  = round_ff;
      w_in      = w_ff;
      s_in      = s_ff;
      h_in      = h_ff;
      dig_in    = dig_ff;
      rem_in    = rem_ff;
      modk_in   = modk_ff;
      idx_in    = idx_ff;
      ctr_in    = ctr_ff;
      op_in     = op_ff;
      token_in  = token_ff;
      hit_in    = hit_ff;
      gcode_in  = gcode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_match_in = rsp_match_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.operation;
               token_in = req_if.token;
               ctr_in   = (req_if.operation == OP_CHECK) ?
                          req_if.time_step - STEP_W'(WINDOW_BACK) : req_if.time_step;
               phase_in = PH_KEY_INNER;
               idx_in   = '0;
               hit_in   = 1'b0;
               gcode_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            for (int i = 0; i < 16; i++) begin
               w_in[i] = blk[511-32*i -: 32];
            end
            state_in = S_INIT;
         end
         S_INIT: begin
            h_in = phase_ff[1] ? rdata_ff : SHA_INIT;
            for (int i = 0; i < 5; i++) begin
               s_in[i] = h_in[159-32*i -: 32];
            end
            round_in = '0;
            state_in = S_RND;
         end
         S_RND: begin
            s_in[0] = t;
            s_in[1] = s_ff[0];
            s_in[2] = rotl(s_ff[1], 30);
            s_in[3] = s_ff[2];
            s_in[4] = s_ff[3];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = wnew;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            dig_in = sum;
            if (phase_ff == PH_MSG_OUTER) begin
               state_in = S_TRUNC;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = S_RD;
            end
         end
         S_TRUNC: begin
            rem_in   = truncate(dig_ff);
            modk_in  = 4'(MOD_STEPS - 1);
            state_in = S_MOD;
         end
         S_MOD: begin
            rem_in  = rem_next;
            modk_in = modk_ff - 4'd1;
            if (modk_ff == '0) begin
               if (op_ff == OP_GENERATE) begin
                  gcode_in = rem_next[19:0];
               end else if (rem_next[19:0] == token_ff) begin
                  hit_in = 1'b1;
               end
               idx_in = idx_ff + WIN_W'(1);
               if (idx_in == codes) begin
                  state_in = S_DONE;
               end else begin
                  ctr_in   = ctr_ff + 32'd1;
                  phase_in = PH_MSG_INNER;
                  state_in = S_RD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = gcode_ff;
               rsp_match_in = hit_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in;
      round_ff <= round_in;
      w_ff     <= w_in;
      s_ff     <= s_in;
      h_ff     <= h_in;
      dig_ff   <= dig_in;
      rem_ff   <= rem_in;
      modk_ff  <= modk_in;
      idx_ff   <= idx_in;
      ctr_ff   <= ctr_in;
      op_ff    <= op_in;
      token_ff <= token_in;
      hit_ff   <= hit_in;
      gcode_ff <= gcode_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_match_ff <= rsp_match_in;
   end

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == S_RD))
      else $error("accepted beat did not start a compression");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> (round_ff < 7'(ROUNDS)))
      else $error("round counter ran past the last round");
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD && modk_ff == '0) |-> (rem_next < 31'(CODE_MODULUS)))
      else $error("reduction left a value of a million or more");
   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result was not posted");
`endif

endmodule
